// ----- src/srrw_pkg.sv -----
package srrw_pkg;

  typedef struct packed {
    logic [15:0] in_seq;
    logic [31:0] in_payload;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [15:0] out_seq;
    logic [31:0] out_payload;
    logic        out_last;
  } out_t;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH   = 3'd0;
  localparam step_t STEP_ACK     = 3'd1;
  localparam step_t STEP_READ    = 3'd2;
  localparam step_t STEP_DELIVER = 3'd3;
  localparam step_t STEP_FLUSH   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FETCH,
    OP_ACK,
    OP_READ,
    OP_DELIVER,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_MARKED,
    COND_OUT_OK
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic marked;
    logic out_ok;
  } flags_t;

  function automatic ctrl_t microcode(input step_t step);
    ctrl_t w;
    case (step)
      STEP_FETCH:   w = '{OP_FETCH,   COND_IN,     STEP_ACK,     STEP_FETCH};
      STEP_ACK:     w = '{OP_ACK,     COND_ALWAYS, STEP_READ,    STEP_READ};
      STEP_READ:    w = '{OP_READ,    COND_MARKED, STEP_DELIVER, STEP_FLUSH};
      STEP_DELIVER: w = '{OP_DELIVER, COND_OUT_OK, STEP_READ,    STEP_DELIVER};
      STEP_FLUSH:   w = '{OP_FLUSH,   COND_OUT_OK, STEP_FETCH,   STEP_FLUSH};
      default:      w = '{OP_NOP,     COND_ALWAYS, STEP_FETCH,   STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ----- src/srrw_ram.sv -----
module srrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/srrw_seq.sv -----
module srrw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  srrw_pkg::flags_t flags,
  output srrw_pkg::ctrl_t  ctrl,
  output logic             go
);

  srrw_pkg::step_t step_r;
  srrw_pkg::step_t step_nxt;

  always_comb begin
    ctrl = srrw_pkg::microcode(step_r);
    case (ctrl.cond)
      srrw_pkg::COND_ALWAYS: go = 1'b1;
      srrw_pkg::COND_IN:     go = flags.in_valid;
      srrw_pkg::COND_MARKED: go = flags.marked;
      srrw_pkg::COND_OUT_OK: go = flags.out_ok;
      default:               go = 1'b0;
    endcase
    step_nxt = go ? ctrl.tgt_true : ctrl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= srrw_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- src/selective_repeat_receive_window.sv -----
// an acknowledgement is registered as the pending result in the ACK step and moves to the output
// register in the next DELIVER or FLUSH step; a new transaction is taken only in the FETCH step,
// after all deliveries it releases and the flush, and in_stall is high in every other step
// output stalls can hold the DELIVER and FLUSH steps while a result is held back
// reset (synchronous, active low) clears the window base, slot marks and sequencer
// slot payload ram is not cleared: a slot is read only after it was written
module selective_repeat_receive_window #(
  parameter int WINDOW       = 4,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  srrw_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output srrw_pkg::out_t  out_data
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W:0]      WIN_S   = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0]    SLOT_MAX = SLOT_W'(WINDOW - 1);
  localparam logic [SEQ_BITS+6:0]  WIN_CMP = (SEQ_BITS + 7)'(WINDOW);

  srrw_pkg::ctrl_t  ctrl;
  srrw_pkg::flags_t flags;
  logic             go;

  logic [SEQ_BITS-1:0]     seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [SEQ_BITS-1:0]     base_r;
  logic [SLOT_W-1:0]       base_slot_r;
  logic [WINDOW-1:0]       rcv_r;
  logic                    pend_v_r;
  srrw_pkg::out_t          pend_r;
  logic                    out_valid_r;
  srrw_pkg::out_t          out_r;

  logic [SEQ_BITS-1:0]     seq_dist;
  logic                    in_win;
  logic                    wrap;
  logic [SLOT_W:0]         sum;
  logic [SLOT_W:0]         sum_red;
  logic [SLOT_W-1:0]       idx;
  logic [SLOT_W-1:0]       base_slot_nxt;
  logic [PAYLOAD_BITS-1:0] ram_rd;
  logic                    out_free;
  logic                    fetch_do;
  logic                    ack_do;
  logic                    del_do;
  logic                    flush_do;
  logic                    push;

  srrw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .go    (go)
  );

  srrw_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ack_do),
    .wr_addr (idx),
    .wr_data (pay_r),
    .rd_addr (base_slot_r),
    .rd_data (ram_rd)
  );

  // slot of an in-window sequence without a modulo: offset from the base slot,
  // or the sequence itself once the window has wrapped past zero
  always_comb begin
    seq_dist = seq_r - base_r;
    in_win   = (SEQ_BITS + 7)'(seq_dist) < WIN_CMP;
    wrap     = seq_r < base_r;
    sum      = {1'b0, base_slot_r} + (SLOT_W + 1)'(seq_dist);
    sum_red  = (sum >= WIN_S) ? sum - WIN_S : sum;
    idx      = wrap ? SLOT_W'(seq_r) : sum_red[SLOT_W-1:0];

    if (base_r == '1) begin
      base_slot_nxt = '0;
    end else if (base_slot_r == SLOT_MAX) begin
      base_slot_nxt = '0;
    end else begin
      base_slot_nxt = base_slot_r + SLOT_W'(1);
    end

    out_free       = !out_valid_r || !out_stall;
    flags.in_valid = in_valid;
    flags.marked   = rcv_r[base_slot_r];
    flags.out_ok   = !pend_v_r || out_free;

    fetch_do = (ctrl.op == srrw_pkg::OP_FETCH) && go;
    ack_do   = (ctrl.op == srrw_pkg::OP_ACK) && in_win && !rcv_r[idx];
    del_do   = (ctrl.op == srrw_pkg::OP_DELIVER) && go;
    flush_do = (ctrl.op == srrw_pkg::OP_FLUSH) && go;
    push     = (del_do || flush_do) && pend_v_r;
  end

  assign in_stall  = (ctrl.op != srrw_pkg::OP_FETCH);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      base_slot_r <= '0;
      rcv_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ack_do) begin
        rcv_r[idx] <= 1'b1;
        pend_v_r   <= 1'b1;
      end
      if (del_do) begin
        rcv_r[base_slot_r] <= 1'b0;
        base_r             <= base_r + SEQ_BITS'(1);
        base_slot_r        <= base_slot_nxt;
        pend_v_r           <= 1'b1;
      end
      if (flush_do) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_do) begin
      seq_r <= SEQ_BITS'(in_data.in_seq);
      pay_r <= PAYLOAD_BITS'(in_data.in_payload);
    end
    if (ack_do) begin
      pend_r <= '{srrw_pkg::KIND_ACK, 16'(seq_r), 32'd0, 1'b0};
    end
    if (del_do) begin
      pend_r <= '{srrw_pkg::KIND_DELIVER, 16'(base_r), 32'(ram_rd), 1'b0};
    end
    if (push) begin
      out_r <= '{pend_r.out_kind, pend_r.out_seq, pend_r.out_payload, flush_do};
    end
  end

`ifndef NO_ASSERTIONS
  a_deliver_marked: assert property (@(posedge clk) disable iff (!rst_n)
    del_do |-> rcv_r[base_slot_r])
    else $error("delivery from an unmarked slot");

  a_base_advance: assert property (@(posedge clk) disable iff (!rst_n)
    del_do |=> base_r == SEQ_BITS'($past(base_r) + SEQ_BITS'(1)))
    else $error("window base did not advance by one on delivery");

  a_fetch_drained: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == srrw_pkg::OP_FETCH |-> !pend_v_r)
    else $error("pending result left over when taking a new transaction");

  a_ack_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.out_kind == srrw_pkg::KIND_ACK |-> out_r.out_payload == '0)
    else $error("acknowledgement carries a payload");
`endif

endmodule
